// ----- rtl/ddcvcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddcvcp_pkg
// Types and constants for the DDC/CI feature-read reply checker.
// ----------------------------------------------------------------------------
package ddcvcp_pkg;

  localparam logic [7:0] SRC_ADDR    = 8'h6e;
  localparam logic [7:0] XOR_SEED    = 8'h50;
  localparam logic [6:0] PAYLOAD_LEN = 7'd8;
  localparam logic [7:0] REPLY_OP    = 8'h02;

  // byte positions within the reply frame
  localparam logic [3:0] IDX_SOURCE  = 4'd0;
  localparam logic [3:0] IDX_LENGTH  = 4'd1;
  localparam logic [3:0] IDX_OPCODE  = 4'd2;
  localparam logic [3:0] IDX_RESULT  = 4'd3;
  localparam logic [3:0] IDX_FEATURE = 4'd4;
  localparam logic [3:0] IDX_MAX_HI  = 4'd6;
  localparam logic [3:0] IDX_MAX_LO  = 4'd7;
  localparam logic [3:0] IDX_CUR_HI  = 4'd8;
  localparam logic [3:0] IDX_CUR_LO  = 4'd9;
  localparam logic [3:0] FRAME_LAST  = 4'd10;
  localparam logic [3:0] IDLE_COUNT  = 4'd11;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SOURCE  = 3'd1,
    ST_BAD_LENGTH  = 3'd2,
    ST_BAD_SUM     = 3'd3,
    ST_BAD_REPLY   = 3'd4,
    ST_UNSUPPORTED = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] expected_feature;
    logic       frame_start;
  } step_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] max_value;
    logic [15:0] current_value;
  } result_t;

  // what the frame tracker tells the pipeline control about the staged byte
  typedef struct packed {
    logic    last;
    result_t res;
  } frame_out_t;

endpackage

// ----- rtl/ddcvcp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddcvcp_if
// Valid/ready channels for reply bytes and check results.
// ----------------------------------------------------------------------------
interface ddcvcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [7:0] expected_feature;
  logic       frame_start;

  modport source (output valid, rx_byte, expected_feature, frame_start, input ready);
  modport sink (input valid, rx_byte, expected_feature, frame_start, output ready);
endinterface

interface ddcvcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] max_value;
  logic [15:0] current_value;

  modport source (output valid, status, max_value, current_value, input ready);
  modport sink (input valid, status, max_value, current_value, output ready);
endinterface

// ----- rtl/ddcvcp_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddcvcp_frame
// Frame state: byte count, running checksum, error flags and captured values.
// ----------------------------------------------------------------------------
module ddcvcp_frame (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step_en,
  input  ddcvcp_pkg::step_t       step,
  output ddcvcp_pkg::frame_out_t  fout
);
  import ddcvcp_pkg::*;

  logic [3:0]  byte_count;
  logic [7:0]  running_xor;
  logic [7:0]  want_feature;
  logic        source_bad;
  logic        length_bad;
  logic        reply_bad;
  logic        unsupported_flag;
  logic [15:0] captured_max;
  logic [7:0]  current_high;
  logic [7:0]  current_low;

  logic [3:0]  idx;
  logic        ignore;
  logic        sum_bad;
  logic [7:0]  xor_base;
  status_t     st;

  assign idx      = step.frame_start ? IDX_SOURCE : byte_count;
  assign ignore   = !step.frame_start && (byte_count > FRAME_LAST);
  assign xor_base = step.frame_start ? XOR_SEED : running_xor;
  assign sum_bad  = running_xor != step.rx_byte;

  always_comb begin
    if (source_bad) begin
      st = ST_BAD_SOURCE;
    end else if (length_bad) begin
      st = ST_BAD_LENGTH;
    end else if (sum_bad) begin
      st = ST_BAD_SUM;
    end else if (reply_bad) begin
      st = ST_BAD_REPLY;
    end else if (unsupported_flag) begin
      st = ST_UNSUPPORTED;
    end else begin
      st = ST_OK;
    end
  end

  assign fout.last              = !step.frame_start && (byte_count == FRAME_LAST);
  assign fout.res.status        = st;
  assign fout.res.max_value     = (st == ST_OK) ? captured_max : 16'd0;
  assign fout.res.current_value = (st == ST_OK) ? {current_high, current_low} : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= IDLE_COUNT;
      running_xor      <= XOR_SEED;
      want_feature     <= 8'd0;
      source_bad       <= 1'b0;
      length_bad       <= 1'b0;
      reply_bad        <= 1'b0;
      unsupported_flag <= 1'b0;
      captured_max     <= 16'd0;
      current_high     <= 8'd0;
      current_low      <= 8'd0;
    end else if (step_en) begin
      if (step.frame_start) begin
        want_feature     <= step.expected_feature;
        length_bad       <= 1'b0;
        reply_bad        <= 1'b0;
        unsupported_flag <= 1'b0;
      end
      if (fout.last) begin
        byte_count <= IDLE_COUNT;
      end else if (!ignore) begin
        running_xor <= xor_base ^ step.rx_byte;
        byte_count  <= idx + 4'd1;
        case (idx)
          IDX_SOURCE:  source_bad <= step.rx_byte != SRC_ADDR;
          IDX_LENGTH:  length_bad <= step.rx_byte[6:0] != PAYLOAD_LEN;
          IDX_OPCODE:  reply_bad <= step.rx_byte != REPLY_OP;
          IDX_RESULT:  unsupported_flag <= step.rx_byte != 8'd0;
          IDX_FEATURE: begin
            if (step.rx_byte != want_feature) begin
              reply_bad <= 1'b1;
            end
          end
          IDX_MAX_HI:  captured_max[15:8] <= step.rx_byte;
          IDX_MAX_LO:  captured_max[7:0] <= step.rx_byte;
          IDX_CUR_HI:  current_high <= step.rx_byte;
          IDX_CUR_LO:  current_low <= step.rx_byte;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/ddcvcp_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddcvcp_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module ddcvcp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ddcvcp_pkg::result_t  data,
  output logic                 free,
  ddcvcp_out_if.source         res
);
  import ddcvcp_pkg::*;

  logic    valid;
  result_t held;

  assign free              = !valid || res.ready;
  assign res.valid         = valid;
  assign res.status        = held.status;
  assign res.max_value     = held.max_value;
  assign res.current_value = held.current_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

endmodule

// ----- rtl/ddc_ci_vcp_reply_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddc_ci_vcp_reply_checker
// Checks an 11-byte DDC/CI feature-read reply and reports status and values.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one reply byte per transfer; frame_start marks byte 0 and
//   expected_feature is sampled with it. Bytes outside an open frame are
//   dropped. A new frame_start restarts the frame without a result.
//   res carries one result per complete frame, on the checksum byte:
//   status, and max/current value (zero unless status is ok).
//   Each byte is taken into an input register; the frame state and the
//   result register are updated as it leaves that register, so a result
//   is shown once the checksum byte has left the input register.
//   One byte per cycle is accepted; the only limit is the result register,
//   which must be free before the checksum byte leaves the input register.
//   When res stalls, bytes keep flowing until a second checksum byte would
//   need the result register, then rx.ready drops.
//   Synchronous reset empties both registers and leaves no frame open.
// ----------------------------------------------------------------------------
module ddc_ci_vcp_reply_checker (
  input  logic         clk,
  input  logic         rst,
  ddcvcp_in_if.sink    rx,
  ddcvcp_out_if.source res
);
  import ddcvcp_pkg::*;

  logic       s1_valid;
  step_t      s1;
  logic       s1_fire;
  logic       out_free;
  frame_out_t fout;

  assign s1_fire  = s1_valid && (!fout.last || out_free);
  assign rx.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1.rx_byte          <= rx.rx_byte;
      s1.expected_feature <= rx.expected_feature;
      s1.frame_start      <= rx.frame_start;
    end
  end

  ddcvcp_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .step_en (s1_fire),
    .step    (s1),
    .fout    (fout)
  );

  ddcvcp_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (s1_fire && fout.last),
    .data (fout.res),
    .free (out_free),
    .res  (res)
  );

endmodule
